[design/kbsb_pkg.sv]
package kbsb_pkg;

	localparam int unsigned NUM_WORDS = 4;
	localparam int unsigned WORD_IDX_W = $clog2(NUM_WORDS);
	localparam int unsigned MSG_POS_W = 5;

	localparam logic [15:0] ALL_UP_WORD = 16'hFFFF;
	localparam logic [15:0] SERIAL_BIT = 16'h8000;

	localparam logic [2:0] CMD_ALL_UP = 3'd0;
	localparam logic [2:0] CMD_SET_WORD = 3'd1;
	localparam logic [2:0] CMD_SET_BIT = 3'd2;
	localparam logic [2:0] CMD_READ_WORD = 3'd3;
	localparam logic [2:0] CMD_LOAD_HOLD = 3'd4;
	localparam logic [2:0] CMD_READ_STATUS = 3'd5;

	localparam logic [3:0] TASK_SERIAL_A = 4'd3;
	localparam logic [3:0] TASK_SERIAL_B = 4'd4;

	typedef struct packed {
		logic [2:0]  command;
		logic [2:0]  word_index;
		logic [15:0] word_value;
		logic [3:0]  bit_index;
		logic        key_down;
		logic [31:0] hold_lines;
		logic [3:0]  task_number;
	} item_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        message_done;
	} result_t;

endpackage

[design/keyboard_serial_backchannel.sv]
// Keyboard serial back-channel. Holds four active-low 16-bit keyboard words
// (all keys up after reset) and serves register-style commands: all keys up,
// set word, set or clear one bit, read word, load boot-hold count, and status
// read. A status read from task 3 or 4 returns 0x8000 while the boot-hold
// count is nonzero (and decrements it), otherwise the next bit of a 32-bit
// message sent MSB first: start 1 at bit 31, word index + 1 at bits 24..27,
// the live word at bits 8..23 and a 1 at bit 7. Messages rotate through
// words 0..3; message_done marks the read that sent the last bit. Every
// command yields exactly one result. Rate: one transfer per cycle on both
// channels while no stall holds them; a result is offered only after its
// item has passed from the item register into the result register. The item
// register and the result register form a two-stage pipeline, and a stall on
// the result channel backs up into item_stall in the same cycle once the item
// register is full.
module keyboard_serial_backchannel (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  kbsb_pkg::item_t     item,
	output logic                result_valid,
	input  logic                result_stall,
	output kbsb_pkg::result_t   result
);
	import kbsb_pkg::*;

	// Input register stage.
	logic  valid_s1;
	item_t item_s1;

	// Block state.
	logic [15:0]           key_words_q [NUM_WORDS];
	logic [WORD_IDX_W-1:0] msg_word_index_q;
	logic [MSG_POS_W-1:0]  msg_bit_pos_q;
	logic [31:0]           boot_hold_left_q;

	// Result register.
	logic    result_valid_q;
	result_t result_q;

	// Next-state signals.
	logic [15:0]           key_words_d [NUM_WORDS];
	logic [WORD_IDX_W-1:0] msg_word_index_d;
	logic [MSG_POS_W-1:0]  msg_bit_pos_d;
	logic [31:0]           boot_hold_left_d;
	result_t               result_d;

	logic                  advance;
	logic                  result_free;
	logic                  idx_ok;
	logic [WORD_IDX_W-1:0] idx;
	logic [15:0]           bit_mask;
	logic [31:0]           message;
	logic                  serial_task;

	// The result register takes a new value when empty or when its transfer
	// completes; the input stage drains into it at that moment.
	assign result_free = !result_valid_q || !result_stall;
	assign advance = valid_s1 && result_free;
	assign item_stall = valid_s1 && !result_free;

	assign idx_ok = (item_s1.word_index[2] == 1'b0);
	assign idx = item_s1.word_index[WORD_IDX_W-1:0];
	assign bit_mask = 16'h0001 << item_s1.bit_index;
	assign serial_task = (item_s1.task_number == TASK_SERIAL_A) ||
		(item_s1.task_number == TASK_SERIAL_B);

	// Message is built from the live word each time a bit goes out.
	assign message = {1'b1, 3'b000, 4'({2'b00, msg_word_index_q} + 4'd1),
		key_words_q[msg_word_index_q], 1'b1, 7'b0000000};

	always_comb begin
		for (int i = 0; i < NUM_WORDS; i++) begin
			key_words_d[i] = key_words_q[i];
		end
		msg_word_index_d = msg_word_index_q;
		msg_bit_pos_d = msg_bit_pos_q;
		boot_hold_left_d = boot_hold_left_q;
		result_d = '0;

		unique case (item_s1.command)
			CMD_ALL_UP: begin
				for (int i = 0; i < NUM_WORDS; i++) begin
					key_words_d[i] = ALL_UP_WORD;
				end
			end
			CMD_SET_WORD: begin
				if (idx_ok) begin
					key_words_d[idx] = item_s1.word_value;
				end
			end
			CMD_SET_BIT: begin
				if (idx_ok) begin
					if (item_s1.key_down) begin
						key_words_d[idx] = key_words_q[idx] & ~bit_mask;
					end else begin
						key_words_d[idx] = key_words_q[idx] | bit_mask;
					end
				end
			end
			CMD_READ_WORD: begin
				result_d.read_data = idx_ok ? key_words_q[idx] : ALL_UP_WORD;
			end
			CMD_LOAD_HOLD: begin
				boot_hold_left_d = item_s1.hold_lines;
			end
			CMD_READ_STATUS: begin
				if (serial_task) begin
					if (boot_hold_left_q != 32'd0) begin
						// Jam high and burn one hold count; message stays put.
						boot_hold_left_d = boot_hold_left_q - 32'd1;
						result_d.read_data = SERIAL_BIT;
					end else begin
						// Bit position 0 selects message bit 31.
						if (message[~msg_bit_pos_q]) begin
							result_d.read_data = SERIAL_BIT;
						end
						msg_bit_pos_d = msg_bit_pos_q + 5'd1;
						if (msg_bit_pos_q == '1) begin
							msg_word_index_d = msg_word_index_q + 2'd1;
							result_d.message_done = 1'b1;
						end
					end
				end
			end
			default: begin
				// Unknown commands change nothing and answer zero.
			end
		endcase
	end

	// Input stage: load on every transfer, drop when drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// State update happens exactly once per item, when it moves to the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				key_words_q[i] <= ALL_UP_WORD;
			end
			msg_word_index_q <= '0;
			msg_bit_pos_q <= '0;
			boot_hold_left_q <= '0;
		end else if (advance) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				key_words_q[i] <= key_words_d[i];
			end
			msg_word_index_q <= msg_word_index_d;
			msg_bit_pos_q <= msg_bit_pos_d;
			boot_hold_left_q <= boot_hold_left_d;
		end
	end

	// Result register: hold while stalled, advance otherwise.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (result_free) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	// The last message bit is always 0.
	a_done_bit_low: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.message_done |-> result_q.read_data == 16'h0000)
		else $error("message_done with serial bit high");

	// Backpressure only appears with an item waiting in the input stage.
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("item_stall without a held item");

	// Finishing a message wraps the bit position and moves to the next word.
	a_done_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		advance && result_d.message_done |=>
		msg_bit_pos_q == '0 && msg_word_index_q == $past(msg_word_index_q) + 2'd1)
		else $error("message end did not wrap");

	// A jammed status read leaves the message position alone.
	a_hold_freezes_msg: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.command == CMD_READ_STATUS && serial_task &&
		boot_hold_left_q != 32'd0 |=> $stable(msg_bit_pos_q))
		else $error("message advanced during boot hold");

endmodule
